FILE: rtl/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds shared widths, opcode and register index codes, and the cell record types.
// No dependencies.
package mlfq_pkg;
   localparam int MaxProcs  = 16;
   localparam int MaxLevels = 4;
   localparam int LevelW    = 3;
   localparam int SvcW      = 16;
   localparam int TickW     = 32;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      REG_NUM_PROCS  = 3'd0,
      REG_NUM_LEVELS = 3'd1,
      REG_QUANTUM0   = 3'd2,
      REG_QUANTUM1   = 3'd3,
      REG_QUANTUM2   = 3'd4
   } reg_index_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic             load;
      logic             admit;
      logic             charge;
      logic [TickW-1:0] now;
      logic [SvcW-1:0]  burst;
      logic [SvcW-1:0]  arrival;
      logic [LevelW-1:0] last_level;
   } cell_cmd_type;

   // Candidate record passed along the chain during selection.
   typedef struct packed {
      logic             found;
      logic [LevelW-1:0] level;
      logic [TickW-1:0] last_tick;
      logic [7:0]       index;
      logic [SvcW-1:0]  remaining;
   } cand_type;
endpackage

FILE: rtl/multilevel_feedback_scheduler.sv
// Multilevel feedback queue scheduler: one load or tick word per command.
// A new word can follow once busy falls. A tick word runs through the admit, scan, charge
// and report states; the candidate record visits the slot cells one cell per cycle in the
// scan, and the result strobe is registered in the report state.
// busy is high while a word is in work. The receiver cannot stall. Synchronous active-high
// reset restores state, configuration and counters. Depends on mlfq_pkg and mlfq_cell.
module multilevel_feedback_scheduler
   import mlfq_pkg::*;
#(
   parameter int MAX_PROCS  = MaxProcs,
   parameter int MAX_LEVELS = MaxLevels
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [3:0]  req_proc_index,
   input  logic [15:0] req_burst_time,
   input  logic [15:0] req_arrival_tick,
   output logic        rsp_strobe,
   output logic [31:0] rsp_tick_number,
   output logic        rsp_grant_valid,
   output logic [3:0]  rsp_granted_index,
   output logic        rsp_completed_valid,
   output logic [31:0] rsp_completed_turnaround,
   output logic        rsp_all_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int IdxW = $clog2(MAX_PROCS);
   localparam int CntW = $clog2(MAX_PROCS + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_ADMIT  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_CHARGE = 6'b010000,
      ST_REPORT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  nproc_ff;
   logic [2:0]  nlev_ff;
   logic [7:0]  q0_ff, q1_ff, q2_ff;
   logic [TickW-1:0] tick_ff;
   logic [IdxW-1:0]  run_ff;
   logic [SvcW-1:0]  qleft_ff;
   logic [4:0]       fin_ff;
   logic             op_ff;
   logic [3:0]       pidx_ff;
   logic [SvcW-1:0]  burst_ff, arr_ff;
   logic [CntW-1:0]  scan_ff;
   cand_type         cand_ff;
   logic             grant_ff, done_ff;
   logic [IdxW-1:0]  sidx_ff;

   logic [CntW-1:0]   n_eff;
   logic [LevelW-1:0] nl_eff, last_lvl;
   cell_cmd_type      cmd;
   cand_type          cand_chain [MAX_PROCS];
   logic [MAX_PROCS-1:0] run_v;
   logic [SvcW-1:0]   rem_v [MAX_PROCS];
   logic [TickW-1:0]  tat_v [MAX_PROCS];
   logic [LevelW-1:0] el_v  [MAX_PROCS];
   logic [IdxW-1:0]   srv_idx;
   logic              srv_any, demote_now, fin_now;
   logic [SvcW-1:0]   qnext;
   cand_type          scan_in;

   always_comb begin
      if (nproc_ff == '0) n_eff = CntW'(1);
      else if (32'(nproc_ff) > MAX_PROCS) n_eff = CntW'(MAX_PROCS);
      else n_eff = CntW'(nproc_ff);
      if (nlev_ff == '0) nl_eff = LevelW'(1);
      else if (32'(nlev_ff) > MAX_LEVELS) nl_eff = LevelW'(MAX_LEVELS);
      else nl_eff = nlev_ff;
      last_lvl = nl_eff - 1'b1;
   end

   assign cmd.load       = (state_ff == ST_LOAD) && (32'(pidx_ff) < MAX_PROCS);
   assign cmd.admit      = (state_ff == ST_ADMIT);
   assign cmd.charge     = (state_ff == ST_CHARGE);
   assign cmd.now        = tick_ff;
   assign cmd.burst      = burst_ff;
   assign cmd.arrival    = arr_ff;
   assign cmd.last_level = last_lvl;

   assign srv_any = grant_ff;
   assign srv_idx = sidx_ff;

   generate
      for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
         cand_type c_in, c_out;
         assign c_in = (32'(scan_ff) == g) ? cand_ff : '0;
         mlfq_cell #(.IdxW(IdxW)) u_cell (
            .clock(clock), .reset(reset),
            .my_index(IdxW'(g)),
            .active(g < n_eff),
            .load_sel(IdxW'(pidx_ff) == IdxW'(g)),
            .cmd(cmd),
            .charge_sel(sidx_ff == IdxW'(g)),
            .demote(demote_now),
            .served_any(srv_any),
            .served_index(srv_idx),
            .cand_in(c_in),
            .cand_out(c_out),
            .runnable(run_v[g]),
            .remaining(rem_v[g]),
            .turnaround(tat_v[g]),
            .eff_level(el_v[g])
         );
         assign cand_chain[g] = c_out;
      end
   endgenerate

   // The scan register walks the chain: at step k it holds the best of cells 0..k-1.
   always_comb begin
      scan_in = cand_ff;
      for (int k = 0; k < MAX_PROCS; k++) begin
         if (32'(scan_ff) == k) scan_in = cand_chain[k];
      end
   end

   assign qnext      = qleft_ff - 1'b1;
   assign fin_now    = grant_ff && (rem_v[sidx_ff] == SvcW'(1));
   assign demote_now = grant_ff && !fin_now && (qnext == '0);

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = (req_opcode == OP_TICK) ? ST_ADMIT : ST_LOAD;
         ST_LOAD:   state_in = ST_IDLE;
         ST_ADMIT:  state_in = ST_SCAN;
         ST_SCAN:   if (32'(scan_ff) == MAX_PROCS) state_in = ST_CHARGE;
         ST_CHARGE: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   logic [7:0] qlv;
   always_comb begin
      case (cand_ff.level)
         3'd0:    qlv = q0_ff;
         3'd1:    qlv = q1_ff;
         default: qlv = q2_ff;
      endcase
      if (qlv == '0) qlv = 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nproc_ff <= 5'd1;
         nlev_ff  <= 3'd1;
         q0_ff    <= 8'd1;
         q1_ff    <= 8'd1;
         q2_ff    <= 8'd1;
         tick_ff  <= 32'd1;
         run_ff   <= '0;
         qleft_ff <= '0;
         fin_ff   <= '0;
         scan_ff  <= '0;
         grant_ff <= 1'b0;
         done_ff  <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NUM_PROCS:  nproc_ff <= csr_data[4:0];
               REG_NUM_LEVELS: nlev_ff  <= csr_data[2:0];
               REG_QUANTUM0:   q0_ff    <= csr_data;
               REG_QUANTUM1:   q1_ff    <= csr_data;
               REG_QUANTUM2:   q2_ff    <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_opcode;
                  pidx_ff  <= req_proc_index;
                  burst_ff <= req_burst_time;
                  arr_ff   <= req_arrival_tick;
               end
               grant_ff <= 1'b0;
            end
            ST_ADMIT: begin
               scan_ff <= '0;
               cand_ff <= '0;
            end
            ST_SCAN: begin
               if (32'(scan_ff) < MAX_PROCS) begin
                  cand_ff <= scan_in;
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  if (qleft_ff != '0 && run_v[run_ff]) begin
                     grant_ff <= 1'b1;
                     sidx_ff  <= run_ff;
                  end else if (cand_ff.found) begin
                     grant_ff <= 1'b1;
                     sidx_ff  <= cand_ff.index[IdxW-1:0];
                     run_ff   <= cand_ff.index[IdxW-1:0];
                     qleft_ff <= (cand_ff.level == last_lvl) ? cand_ff.remaining
                                                             : SvcW'(qlv);
                  end else begin
                     grant_ff <= 1'b0;
                     qleft_ff <= '0;
                  end
               end
            end
            ST_CHARGE: begin
               done_ff <= fin_now;
               rsp_completed_turnaround <= fin_now ? tat_v[sidx_ff] + 1'b1 : '0;
               if (grant_ff) begin
                  qleft_ff <= fin_now ? '0 : qnext;
                  if (fin_now && fin_ff < 5'd31) fin_ff <= fin_ff + 1'b1;
               end
            end
            ST_REPORT: begin
               rsp_strobe          <= 1'b1;
               rsp_tick_number     <= tick_ff;
               rsp_grant_valid     <= grant_ff;
               rsp_granted_index   <= grant_ff ? 4'(sidx_ff) : 4'd0;
               rsp_completed_valid <= done_ff;
               rsp_all_done        <= (32'(fin_ff) >= 32'(n_eff));
               tick_ff             <= tick_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   logic unused_bits;
   assign unused_bits = op_ff ^ (^el_v[0]);
endmodule

FILE: rtl/mlfq_cell.sv
// One process slot of the scheduler chain.
// Holds the slot state and merges its own candidate into the record from the scan register.
// Depends on mlfq_pkg.
module mlfq_cell
   import mlfq_pkg::*;
#(
   parameter int IdxW = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IdxW-1:0]  my_index,
   input  logic             active,
   input  logic             load_sel,
   input  cell_cmd_type     cmd,
   input  logic             charge_sel,
   input  logic             demote,
   input  logic             served_any,
   input  logic [IdxW-1:0]  served_index,
   input  cand_type         cand_in,
   output cand_type         cand_out,
   output logic             runnable,
   output logic [SvcW-1:0]  remaining,
   output logic [TickW-1:0] turnaround,
   output logic [LevelW-1:0] eff_level
);
   logic [SvcW-1:0]   rem_ff, rem_in;
   logic [LevelW-1:0] lvl_ff, lvl_in;
   logic              arr_ff, arr_in;
   logic [SvcW-1:0]   atime_ff, atime_in;
   logic [TickW-1:0]  last_ff, last_in;
   logic [TickW-1:0]  tat_ff, tat_in;
   logic              better;

   assign eff_level  = (lvl_ff >= cmd.last_level) ? cmd.last_level : lvl_ff;
   assign runnable   = active && arr_ff && (rem_ff != '0);
   assign remaining  = rem_ff;
   assign turnaround = tat_ff;

   always_comb begin
      better = runnable && (!cand_in.found || eff_level < cand_in.level ||
               (eff_level == cand_in.level && last_ff < cand_in.last_tick));
      cand_out = cand_in;
      if (better) begin
         cand_out.found     = 1'b1;
         cand_out.level     = eff_level;
         cand_out.last_tick = last_ff;
         cand_out.index     = 8'(my_index);
         cand_out.remaining = rem_ff;
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      lvl_in   = lvl_ff;
      arr_in   = arr_ff;
      atime_in = atime_ff;
      last_in  = last_ff;
      tat_in   = tat_ff;
      if (cmd.load && load_sel) begin
         rem_in   = cmd.burst;
         atime_in = cmd.arrival;
         arr_in   = 1'b0;
         lvl_in   = '0;
         tat_in   = '0;
      end
      if (cmd.admit && active && !arr_ff && (TickW'(atime_ff) == cmd.now - 1'b1)) begin
         arr_in  = 1'b1;
         lvl_in  = '0;
         last_in = cmd.now;
      end
      if (cmd.charge && served_any) begin
         if (charge_sel) begin
            rem_in  = rem_ff - 1'b1;
            last_in = cmd.now;
            if (demote) begin
               lvl_in = (eff_level < cmd.last_level) ? eff_level + 1'b1 : eff_level;
            end
         end
         if (active && arr_ff && (charge_sel || rem_ff != '0)) begin
            tat_in = tat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         lvl_ff <= '0;
         arr_ff <= 1'b0;
         tat_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         lvl_ff <= lvl_in;
         arr_ff <= arr_in;
         tat_ff <= tat_in;
      end
      atime_ff <= atime_in;
      last_ff  <= last_in;
   end

   logic unused_served;
   assign unused_served = ^served_index;
endmodule
